// File: hdl/piston_wall_force_update_assert.svh
// ----------------------------------------------------------------------------
// piston wall force update assertion macros
// shared concurrent assertion forms, clocked on clk, held off during arst_n
// ----------------------------------------------------------------------------
`ifndef PISTON_WALL_FORCE_UPDATE_ASSERT_SVH
`define PISTON_WALL_FORCE_UPDATE_ASSERT_SVH

// same-cycle implication
`define PWF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PWF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/pwf_pkg.sv
// ----------------------------------------------------------------------------
// pwf_pkg
// shared types, constants and helpers of the piston wall force update block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pwf_pkg;

	// fixed point format
	localparam int FRAC_BITS = 16;

	// magnitude width and saturation cap of the kick arithmetic
	localparam int MAG_W  = 62;
	localparam int PROD_W = 128;
	localparam logic [MAG_W-1:0] MAG_CAP = {MAG_W{1'b1}};
	localparam logic [MAG_W-1:0] CAP_DIV24 = MAG_CAP / 62'd24;
	localparam logic [MAG_W-1:0] CAP_DIV48 = MAG_CAP / 62'd48;

	// reciprocal divider sizes
	localparam int DIV_W  = 2 * FRAC_BITS + 1;
	localparam int DCNT_W = $clog2(DIV_W + 1);

	// register indexes
	localparam logic [1:0] REG_PISTON = 2'd0;
	localparam logic [1:0] REG_CUTOFF = 2'd1;
	localparam logic [1:0] REG_SHIFT  = 2'd2;
	localparam logic [1:0] REG_DT     = 2'd3;

	// register reset values
	localparam logic [31:0] RST_PISTON = 32'd0;
	localparam logic [30:0] RST_CUTOFF = 31'd196608;
	localparam logic [31:0] RST_SHIFT  = 32'd0;
	localparam logic [30:0] RST_DT     = 31'd65;

	// multiply steps of one kick
	localparam logic [2:0] STEP_V2  = 3'd0;
	localparam logic [2:0] STEP_V4  = 3'd1;
	localparam logic [2:0] STEP_V8  = 3'd2;
	localparam logic [2:0] STEP_V12 = 3'd3;
	localparam logic [2:0] STEP_V14 = 3'd4;
	localparam logic [2:0] STEP_F   = 3'd5;
	localparam logic [2:0] STEP_KM  = 3'd6;

	typedef struct packed {
		logic [31:0] piston_position;
		logic [30:0] cutoff_dist;
		logic [31:0] shift_coefficient;
		logic [30:0] time_step;
	} pwf_cfg_t;

	typedef struct packed {
		logic       load;
		logic       kick_pist;
		logic       div_start;
		logic       mul_start;
		logic       mul_wr;
		logic [2:0] step;
		logic       calc_t;
		logic       apply;
		logic       out_load;
	} pwf_cmd_t;

	typedef struct packed {
		logic floor_hit;
		logic pist_hit;
		logic div_done;
		logic mul_done;
	} pwf_sts_t;

	// product shifted down by the fraction, saturated at the cap
	function automatic logic [MAG_W-1:0] mulq_cap(input logic [PROD_W-1:0] p);
		logic [MAG_W-1:0] r;
		if (|p[PROD_W-1:FRAC_BITS+MAG_W]) begin
			r = MAG_CAP;
		end else begin
			r = p[FRAC_BITS+MAG_W-1:FRAC_BITS];
		end
		return r;
	endfunction

endpackage

// File: hdl/piston_wall_force_update.sv
// ----------------------------------------------------------------------------
// piston_wall_force_update
// floor and piston wall kicks on a stream of particle words
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid/in_ready carries pos_z, mom_z and sweep_start;
//   output channel out_valid/out_ready carries new_mom_z and impulse_total.
//   one word in gives exactly one word out, in order.
//   registers sit on an apb-style port at byte offsets 0, 4, 8, 12.
//   each kick is a 33-step restoring reciprocal divide plus seven products
//   on one 32x32 multiplier taken in four partial products each. one
//   particle is worked on at a time and the next word is taken the cycle
//   after the result is loaded.
//   the finished word waits in an output register, so the next word is taken
//   while it is still unclaimed; a stall then holds only the next finish.
//   reset clears the impulse, restores register defaults and empties the
//   output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module piston_wall_force_update (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] pos_z,
	input  logic [31:0] mom_z,
	input  logic        sweep_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] new_mom_z,
	output logic [47:0] impulse_total
);

	pwf_pkg::pwf_cfg_t cfg;
	pwf_pkg::pwf_cmd_t cmd;
	pwf_pkg::pwf_sts_t sts;

	// register file
	pwf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer
	pwf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath
	pwf_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.sts           (sts),
		.pos_z         (pos_z),
		.mom_z         (mom_z),
		.sweep_start   (sweep_start),
		.new_mom_z     (new_mom_z),
		.impulse_total (impulse_total)
	);

endmodule

// File: hdl/pwf_regs.sv
// ----------------------------------------------------------------------------
// pwf_regs
// configuration register file behind the apb-style port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwf_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output pwf_pkg::pwf_cfg_t cfg
);

	pwf_pkg::pwf_cfg_t cfg_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.piston_position   <= pwf_pkg::RST_PISTON;
			cfg_q.cutoff_dist       <= pwf_pkg::RST_CUTOFF;
			cfg_q.shift_coefficient <= pwf_pkg::RST_SHIFT;
			cfg_q.time_step         <= pwf_pkg::RST_DT;
		end else if (wr_en) begin
			case (paddr[3:2])
				pwf_pkg::REG_PISTON: cfg_q.piston_position   <= pwdata;
				pwf_pkg::REG_CUTOFF: cfg_q.cutoff_dist       <= pwdata[30:0];
				pwf_pkg::REG_SHIFT:  cfg_q.shift_coefficient <= pwdata;
				pwf_pkg::REG_DT:     cfg_q.time_step         <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (paddr[3:2])
			pwf_pkg::REG_PISTON: prdata = cfg_q.piston_position;
			pwf_pkg::REG_CUTOFF: prdata = {1'b0, cfg_q.cutoff_dist};
			pwf_pkg::REG_SHIFT:  prdata = cfg_q.shift_coefficient;
			pwf_pkg::REG_DT:     prdata = {1'b0, cfg_q.time_step};
			default:             prdata = 32'd0;
		endcase
	end

endmodule

// File: hdl/pwf_dp.sv
// ----------------------------------------------------------------------------
// pwf_dp
// datapath: particle registers, reciprocal divider, shared multiplier, kick
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwf_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  pwf_pkg::pwf_cfg_t cfg,
	input  pwf_pkg::pwf_cmd_t cmd,
	output pwf_pkg::pwf_sts_t sts,
	input  logic [31:0]       pos_z,
	input  logic [31:0]       mom_z,
	input  logic              sweep_start,
	output logic [31:0]       new_mom_z,
	output logic [47:0]       impulse_total
);

	localparam int MW = pwf_pkg::MAG_W;
	localparam int DW = pwf_pkg::DIV_W;
	localparam int CW = pwf_pkg::DCNT_W;

	logic [31:0] q_q, mom_q, nm_q;
	logic [47:0] imp_q, it_q;

	// kick operands and intermediate powers
	logic [31:0]              a_q;
	logic                     dneg_q;
	logic [31:0]              rem_q;
	logic [DW-1:0]            dvd_q;
	logic [CW-1:0]            dcnt_q;
	logic [MW-1:0] v2_q, v4_q, v8_q, v12_q, v14_q, f_q, km_q, tm_q;
	logic          tneg_q;

	// multiplier state
	logic [MW-1:0]     mx_q, my_q;
	logic [pwf_pkg::PROD_W-1:0] macc_q;
	logic [1:0]        mcnt_q;
	logic              mbusy_q;

	// distance select
	logic signed [33:0] pdz_w;
	logic [31:0]        pdz_sat, dz_w, a_w;
	logic               zero_w;

	assign pdz_w = $signed({{2{cfg.piston_position[31]}}, cfg.piston_position})
		- $signed({{2{q_q[31]}}, q_q}) + $signed({3'b000, cfg.cutoff_dist});

	always_comb begin
		if (pdz_w > 34'sd2147483647) begin
			pdz_sat = 32'h7FFF_FFFF;
		end else if (pdz_w < -34'sd2147483648) begin
			pdz_sat = 32'h8000_0000;
		end else begin
			pdz_sat = pdz_w[31:0];
		end
		dz_w   = cmd.kick_pist ? pdz_sat : q_q;
		a_w    = dz_w[31] ? (32'd0 - dz_w) : dz_w;
		zero_w = (a_w == 32'd0);
	end

	// status
	assign sts.floor_hit = $signed(q_q) < $signed({1'b0, cfg.cutoff_dist});
	assign sts.pist_hit  = $signed(q_q) > $signed(cfg.piston_position);
	assign sts.div_done  = (dcnt_q == '0);
	assign sts.mul_done  = !mbusy_q;

	// restoring divider step
	logic [32:0] dsh_w;
	logic        dge_w;
	assign dsh_w = {rem_q, dvd_q[DW-1]};
	assign dge_w = dsh_w >= {1'b0, a_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.div_start) begin
			dcnt_q <= CW'(DW);
		end else if (dcnt_q != '0) begin
			dcnt_q <= dcnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			a_q    <= zero_w ? 32'd1 : a_w;
			dneg_q <= zero_w ? 1'b0 : dz_w[31];
			rem_q  <= '0;
			dvd_q  <= {1'b1, {(DW-1){1'b0}}};
		end else if (dcnt_q != '0) begin
			rem_q <= dge_w ? 32'(dsh_w - {1'b0, a_q}) : dsh_w[31:0];
			dvd_q <= {dvd_q[DW-2:0], dge_w};
		end
	end

	// multiplier operand select
	logic [MW-1:0] opx_w, opy_w, v_w, mres_w;
	assign v_w = MW'(dvd_q);

	always_comb begin
		case (cmd.step)
			pwf_pkg::STEP_V2:  begin opx_w = v_w;   opy_w = v_w;  end
			pwf_pkg::STEP_V4:  begin opx_w = v2_q;  opy_w = v2_q; end
			pwf_pkg::STEP_V8:  begin opx_w = v4_q;  opy_w = v4_q; end
			pwf_pkg::STEP_V12: begin opx_w = v8_q;  opy_w = v4_q; end
			pwf_pkg::STEP_V14: begin opx_w = v12_q; opy_w = v2_q; end
			pwf_pkg::STEP_F:   begin opx_w = tm_q;  opy_w = MW'(cfg.time_step); end
			pwf_pkg::STEP_KM:  begin opx_w = f_q;   opy_w = MW'(a_q); end
			default:           begin opx_w = '0;    opy_w = '0;   end
		endcase
	end

	// one 32x32 partial product per cycle
	logic [31:0]  xp_w, yp_w;
	logic [63:0]  pp_w;
	logic [1:0]   psh_w;
	assign xp_w  = mcnt_q[0] ? {2'b00, mx_q[MW-1:32]} : mx_q[31:0];
	assign yp_w  = mcnt_q[1] ? {2'b00, my_q[MW-1:32]} : my_q[31:0];
	assign pp_w  = xp_w * yp_w;
	assign psh_w = {1'b0, mcnt_q[0]} + {1'b0, mcnt_q[1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mcnt_q  <= '0;
		end else if (cmd.mul_start) begin
			mbusy_q <= 1'b1;
			mcnt_q  <= '0;
		end else if (mbusy_q) begin
			mcnt_q <= mcnt_q + 2'd1;
			if (mcnt_q == 2'd3) begin
				mbusy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			mx_q   <= opx_w;
			my_q   <= opy_w;
			macc_q <= '0;
		end else if (mbusy_q) begin
			macc_q <= macc_q + ({64'd0, pp_w} << {psh_w, 5'd0});
		end
	end

	assign mres_w = pwf_pkg::mulq_cap(macc_q);

	// product write back
	always_ff @(posedge clk) begin
		if (cmd.mul_wr) begin
			case (cmd.step)
				pwf_pkg::STEP_V2:  v2_q  <= mres_w;
				pwf_pkg::STEP_V4:  v4_q  <= mres_w;
				pwf_pkg::STEP_V8:  v8_q  <= mres_w;
				pwf_pkg::STEP_V12: v12_q <= mres_w;
				pwf_pkg::STEP_V14: v14_q <= mres_w;
				pwf_pkg::STEP_F:   f_q   <= mres_w;
				pwf_pkg::STEP_KM:  km_q  <= mres_w;
				default: ;
			endcase
		end
	end

	// force term t = 24 v8 - 48 v14 + 8 shift_coefficient, clamped, split into sign and magnitude
	logic [MW-1:0]      s8_w, s14_w;
	logic signed [65:0] c8_w, t_w;
	logic [65:0]        tmag_w;
	always_comb begin
		s8_w  = (v8_q > pwf_pkg::CAP_DIV24) ? pwf_pkg::MAG_CAP
			: MW'({v8_q, 4'd0} + {1'b0, v8_q, 3'd0});
		s14_w = (v14_q > pwf_pkg::CAP_DIV48) ? pwf_pkg::MAG_CAP
			: MW'({v14_q, 5'd0} + {1'b0, v14_q, 4'd0});
		c8_w  = $signed({{31{cfg.shift_coefficient[31]}}, cfg.shift_coefficient, 3'd0});
		t_w   = $signed({4'd0, s8_w}) - $signed({4'd0, s14_w}) + c8_w;
		tmag_w = t_w[65] ? 66'(-t_w) : t_w;
	end

	always_ff @(posedge clk) begin
		if (cmd.calc_t) begin
			tneg_q <= t_w[65];
			tm_q   <= (tmag_w > {4'd0, pwf_pkg::MAG_CAP}) ? pwf_pkg::MAG_CAP : tmag_w[MW-1:0];
		end
	end

	// apply the kick to momentum and impulse
	logic signed [63:0] ks_w, msum_w, isum_w;
	logic [31:0]        msat_w;
	logic [47:0]        isat_w;
	always_comb begin
		ks_w   = (tneg_q ^ dneg_q) ? -$signed({2'b00, km_q}) : $signed({2'b00, km_q});
		msum_w = $signed({{32{mom_q[31]}}, mom_q}) + (cmd.kick_pist ? ks_w : -ks_w);
		isum_w = $signed({{16{imp_q[47]}}, imp_q}) - ks_w;
		if (msum_w > 64'sd2147483647) begin
			msat_w = 32'h7FFF_FFFF;
		end else if (msum_w < -64'sd2147483648) begin
			msat_w = 32'h8000_0000;
		end else begin
			msat_w = msum_w[31:0];
		end
		if (isum_w > 64'sd140737488355327) begin
			isat_w = 48'h7FFF_FFFF_FFFF;
		end else if (isum_w < -64'sd140737488355328) begin
			isat_w = 48'h8000_0000_0000;
		end else begin
			isat_w = isum_w[47:0];
		end
	end

	// running impulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			imp_q <= '0;
		end else if (cmd.load && sweep_start) begin
			imp_q <= '0;
		end else if (cmd.apply && cmd.kick_pist) begin
			imp_q <= isat_w;
		end
	end

	// particle word and output register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			q_q   <= pos_z;
			mom_q <= mom_z;
		end else if (cmd.apply) begin
			mom_q <= msat_w;
		end
		if (cmd.out_load) begin
			nm_q <= mom_q;
			it_q <= imp_q;
		end
	end

	assign new_mom_z     = nm_q;
	assign impulse_total = it_q;

endmodule

// File: hdl/pwf_ctrl.sv
// ----------------------------------------------------------------------------
// pwf_ctrl
// sequencer: floor kick, piston kick, divider and multiply steps, output word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "piston_wall_force_update_assert.svh"

module pwf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  pwf_pkg::pwf_sts_t sts,
	output pwf_pkg::pwf_cmd_t cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CHK    = 4'd1;
	localparam logic [3:0] S_DSTART = 4'd2;
	localparam logic [3:0] S_DWAIT  = 4'd3;
	localparam logic [3:0] S_MSTART = 4'd4;
	localparam logic [3:0] S_MWAIT  = 4'd5;
	localparam logic [3:0] S_TCALC  = 4'd6;
	localparam logic [3:0] S_APPLY  = 4'd7;
	localparam logic [3:0] S_FIN    = 4'd8;

	logic [3:0] state_q, state_d;
	logic [2:0] step_q, step_d;
	logic       pist_q, pist_d;
	logic       out_valid_q;
	logic       acc_w, km_end_w, pist_next_w;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		pist_d  = pist_q;
		cmd     = '0;
		cmd.step      = step_q;
		cmd.kick_pist = pist_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.floor_hit) begin
					pist_d  = 1'b0;
					state_d = S_DSTART;
				end else if (sts.pist_hit) begin
					pist_d  = 1'b1;
					state_d = S_DSTART;
				end else begin
					state_d = S_FIN;
				end
			end
			S_DSTART: begin
				cmd.div_start = 1'b1;
				state_d       = S_DWAIT;
			end
			S_DWAIT: begin
				if (sts.div_done) begin
					step_d  = pwf_pkg::STEP_V2;
					state_d = S_MSTART;
				end
			end
			S_MSTART: begin
				cmd.mul_start = 1'b1;
				state_d       = S_MWAIT;
			end
			S_MWAIT: begin
				if (sts.mul_done) begin
					cmd.mul_wr = 1'b1;
					if (step_q == pwf_pkg::STEP_KM) begin
						state_d = S_APPLY;
					end else begin
						step_d  = step_q + 3'd1;
						state_d = (step_q == pwf_pkg::STEP_V14) ? S_TCALC : S_MSTART;
					end
				end
			end
			S_TCALC: begin
				cmd.calc_t = 1'b1;
				state_d    = S_MSTART;
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				if (!pist_q && sts.pist_hit) begin
					pist_d  = 1'b1;
					state_d = S_DSTART;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= pwf_pkg::STEP_V2;
			pist_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			pist_q  <= pist_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// checks
	assign acc_w       = in_valid && in_ready;
	assign km_end_w    = (state_q == S_MWAIT) && sts.mul_done && (step_q == pwf_pkg::STEP_KM);
	assign pist_next_w = (state_q == S_APPLY) && !pist_q && sts.pist_hit;

	`PWF_ASSERT_NXT(a_accept_chk, acc_w, state_q == S_CHK, "accept did not check")
	`PWF_ASSERT_NXT(a_km_apply, km_end_w, state_q == S_APPLY, "last product not applied")
	`PWF_ASSERT_NXT(a_floor_then_pist, pist_next_w, state_q == S_DSTART && pist_q, "piston kick skipped")
	`PWF_ASSERT_IMP(a_start_excl, cmd.div_start, !cmd.mul_start && !cmd.apply, "divider and multiplier started together")

endmodule

// File: sim/tb_piston_wall_force_update.sv
// ----------------------------------------------------------------------------
// tb_piston_wall_force_update
// streams particle words through the wall kick block and checks every result
// word against a bit-accurate predictor of the floor and piston kicks, with
// random idling on both channels and register changes between phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_piston_wall_force_update;

	localparam logic [63:0] KCAP = 64'h3FFF_FFFF_FFFF_FFFF;
	localparam longint MAX48 = 64'sh7FFF_FFFF_FFFF;

	typedef struct {
		logic [31:0] pos;
		logic [31:0] mom;
		logic        start;
	} particle_t;

	typedef struct {
		logic [31:0] mom;
		logic [47:0] imp;
	} kick_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [31:0] pos_z = '0, mom_z = '0;
	logic sweep_start = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] new_mom_z;
	logic [47:0] impulse_total;

	piston_wall_force_update dut (.*);

	always #10 clk = ~clk;

	// predictor copy of the registers and impulse
	longint m_piston, m_cutoff, m_shift, m_dt, m_imp;

	particle_t pending_q[$];
	kick_res_t expected_q[$];
	int errors = 0;
	int n_words = 0;
	logic hold_arm = 1'b0;
	logic hold_on = 1'b0;

	function automatic logic [63:0] mul_frac(logic [63:0] x, logic [63:0] y);
		logic [127:0] p;
		logic [127:0] r;
		p = x * y;
		r = p >> pwf_pkg::FRAC_BITS;
		if (r > {64'd0, KCAP}) return KCAP;
		return r[63:0];
	endfunction

	function automatic logic [63:0] scale_cap(logic [63:0] v, logic [63:0] k);
		return (v > KCAP / k) ? KCAP : v * k;
	endfunction

	function automatic longint kick_of(longint dz);
		logic dneg;
		logic [63:0] a, v, v2, v4, v8, v14, tm, f, km;
		longint t;
		logic tneg;
		dneg = dz < 0;
		a = dneg ? -dz : dz;
		if (a == 0) begin
			a = 1;
			dneg = 1'b0;
		end
		v = (64'd1 << (2 * pwf_pkg::FRAC_BITS)) / a;
		v2 = mul_frac(v, v);
		v4 = mul_frac(v2, v2);
		v8 = mul_frac(v4, v4);
		v14 = mul_frac(mul_frac(v8, v4), v2);
		t = longint'(scale_cap(v8, 24)) - longint'(scale_cap(v14, 48)) + 8 * m_shift;
		if (t > longint'(KCAP)) t = KCAP;
		if (t < -longint'(KCAP)) t = -longint'(KCAP);
		tneg = t < 0;
		tm = tneg ? -t : t;
		f = mul_frac(tm, m_dt);
		km = mul_frac(f, a);
		return (tneg != dneg) ? -longint'(km) : longint'(km);
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic kick_res_t predict_kick(particle_t p);
		longint q, m, k, acc;
		kick_res_t r;
		q = longint'(signed'(p.pos));
		m = longint'(signed'(p.mom));
		if (p.start) m_imp = 0;
		if (q < m_cutoff) m = clamp32(m - kick_of(q));
		if (q > m_piston) begin
			k = kick_of(clamp32(m_piston - q + m_cutoff));
			acc = m_imp - k;
			m = clamp32(m + k);
			if (acc > MAX48) acc = MAX48;
			if (acc < -MAX48 - 1) acc = -MAX48 - 1;
			m_imp = acc;
		end
		r.mom = m[31:0];
		r.imp = m_imp[47:0];
		return r;
	endfunction

	// register write, two-phase
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			pwf_pkg::REG_PISTON: m_piston = longint'(signed'(val));
			pwf_pkg::REG_CUTOFF: m_cutoff = val[30:0];
			pwf_pkg::REG_SHIFT:  m_shift = longint'(signed'(val));
			pwf_pkg::REG_DT:     m_dt = val[30:0];
			default: ;
		endcase
	endtask

	task automatic add_word(logic [31:0] p, logic [31:0] m, logic s);
		particle_t w;
		w.pos = p; w.mom = m; w.start = s;
		pending_q.push_back(w);
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// near-wall, random or extreme position for the current settings
	function automatic logic [31:0] rand_pos();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 8) - 4;
			2: return m_cutoff[31:0] - $urandom_range(0, 400000);
			3: return m_piston[31:0] + $urandom_range(1, 400000);
			4: return m_piston[31:0] + m_cutoff[31:0] + $urandom_range(0, 8) - 4;
			default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		endcase
	endfunction

	// input driver
	int in_gap = 0;
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			expected_q.push_back(predict_kick(pending_q.pop_front()));
			in_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 8) : 0;
		end
		if (!(in_valid && !in_ready)) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_q.size() != 0) begin
				in_valid <= 1'b1;
				pos_z <= pending_q[0].pos;
				mom_z <= pending_q[0].mom;
				sweep_start <= pending_q[0].start;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold, counted on its own
	initial begin
		wait (hold_arm);
		hold_on = 1'b1;
		repeat (1500) @(posedge clk);
		hold_on = 1'b0;
	end

	// result monitor with random back-pressure
	int out_gap = 0;
	always @(posedge clk) begin
		kick_res_t e;
		if (out_valid && out_ready) begin
			n_words++;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word mom=%h imp=%h", $time, new_mom_z, impulse_total);
			end else begin
				e = expected_q.pop_front();
				if (new_mom_z !== e.mom) begin
					errors++;
					$display("%0t: new_mom_z expected %h actual %h", $time, e.mom, new_mom_z);
				end
				if (impulse_total !== e.imp) begin
					errors++;
					$display("%0t: impulse_total expected %h actual %h", $time, e.imp,
						impulse_total);
				end
			end
			out_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 8) : 0;
		end
		if (hold_on) begin
			out_ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// stimulus
	initial begin
		m_piston = 0; m_cutoff = 196608; m_shift = 0; m_dt = 65; m_imp = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// directed words at reset settings
		add_word(32'd0, 32'd0, 1'b1);
		add_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		add_word(32'h8000_0000, 32'h8000_0000, 1'b0);
		add_word(32'd196608, 32'd1000, 1'b0);
		add_word(32'd196607, 32'hFFFF_FFFF, 1'b0);
		add_word(32'd1, 32'd0, 1'b0);
		add_word(32'hFFFF_FFFF, 32'd0, 1'b1);
		add_word(32'd65536, 32'h7FFF_FFF0, 1'b0);
		add_word(32'd196608, 32'h8000_0010, 1'b0);
		drain();
		write_reg(pwf_pkg::REG_PISTON, 32'h8000_0000);
		write_reg(pwf_pkg::REG_CUTOFF, 32'h7FFF_FFFF);
		write_reg(pwf_pkg::REG_SHIFT, 32'h7FFF_FFFF);
		write_reg(pwf_pkg::REG_DT, 32'h7FFF_FFFF);
		add_word(32'h7FFF_FFFF, 32'd5, 1'b1);
		add_word(32'h8000_0001, 32'd5, 1'b0);
		add_word(32'd0, 32'd0, 1'b0);
		add_word(32'h4000_0000, 32'h8000_0000, 1'b0);
		drain();
		write_reg(pwf_pkg::REG_SHIFT, 32'h8000_0000);
		write_reg(pwf_pkg::REG_CUTOFF, 32'd0);
		write_reg(pwf_pkg::REG_PISTON, 32'h7FFF_FFFF);
		write_reg(pwf_pkg::REG_DT, 32'd0);
		add_word(32'h8000_0000, 32'd7, 1'b1);
		add_word(32'd0, 32'd7, 1'b0);
		add_word(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		drain();
		// long receiver hold while the sender keeps offering
		write_reg(pwf_pkg::REG_PISTON, 32'd327680);
		write_reg(pwf_pkg::REG_CUTOFF, 32'd196608);
		write_reg(pwf_pkg::REG_SHIFT, 32'd0);
		write_reg(pwf_pkg::REG_DT, 32'd65536);
		hold_arm = 1'b1;
		repeat (12) add_word(32'd400000, $urandom(), 1'b0);
		drain();
		// random phases over several settings
		for (int ph = 0; ph < 10; ph++) begin
			write_reg(pwf_pkg::REG_PISTON,
				ph % 3 == 0 ? $urandom() : $urandom_range(0, 1 << 22));
			write_reg(pwf_pkg::REG_CUTOFF,
				ph % 4 == 0 ? $urandom() : $urandom_range(0, 1 << 19));
			write_reg(pwf_pkg::REG_SHIFT,
				ph % 2 == 0 ? $urandom() : $urandom_range(0, 512) - 256);
			write_reg(pwf_pkg::REG_DT,
				ph % 5 == 0 ? $urandom() : $urandom_range(0, 1 << 17));
			for (int i = 0; i < 98; i++)
				add_word(rand_pos(), $urandom(), $urandom_range(0, 15) == 0);
			drain();
		end
		$display("run covered %0d result words over directed, stall and random phases", n_words);
		$display("register settings included both extremes of every field");
		if (errors == 0) begin
			$display("[piston_wall_force_update] OK");
		end else begin
			$display("[piston_wall_force_update] ERROR");
		end
		$finish;
	end

	// timeout
	initial begin
		#20ms;
		$display("[piston_wall_force_update] ERROR");
		$finish;
	end

endmodule
